/* sv/lkat_pkg.sv */
`timescale 1ns / 1ps

package lkat_pkg;

  localparam int AxisFrac = 30;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    word_t eye_x;
    word_t eye_y;
    word_t eye_z;
    word_t target_x;
    word_t target_y;
    word_t target_z;
    word_t up_x;
    word_t up_y;
    word_t up_z;
  } in_t;

  typedef struct packed {
    word_t right_x;
    word_t right_y;
    word_t right_z;
    word_t true_up_x;
    word_t true_up_y;
    word_t true_up_z;
    word_t back_x;
    word_t back_y;
    word_t back_z;
    word_t trans_x;
    word_t trans_y;
    word_t trans_z;
  } out_t;

endpackage

/* sv/lkat_chan_if.sv */
`timescale 1ns / 1ps

interface lkat_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/lkat_norm.sv */
`timescale 1ns / 1ps

module lkat_norm import lkat_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  wide_t             vec_i [3],
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output word_t             vec_o [3],
  output logic [SIDE_W-1:0] side_o
);

  localparam int Iter   = 32;
  localparam int Steps  = 2;
  localparam int SqN    = Iter / Steps;
  localparam int DvN    = Iter / Steps;
  localparam int SqLo   = 6;
  localparam int SdIdx  = SqLo + SqN;
  localparam int OutIdx = SdIdx + 1 + DvN;
  localparam int NSt    = OutIdx + 1;

  logic [NSt-1:0]    vld_q;
  logic [NSt-1:0]    zero_q;
  logic [2:0]        neg_q  [NSt];
  logic [SIDE_W-1:0] side_q [NSt];

  logic [62:0] mag_d [3];
  logic [2:0]  neg_d;
  logic        zero_d;
  logic [62:0] mx_d;
  logic [62:0] mag_q [3][3];
  logic [62:0] mx_q;
  logic [63:0] mx64;
  logic [2:0]  grp_d, grp_q;
  logic [7:0]  byte_d, byte_q;
  logic [5:0]  pos_d, pos_q;
  logic [30:0] m_d [3];
  logic [30:0] m_q [3:SdIdx-1][3];
  logic [61:0] sq_q [3];
  logic [63:0] sum_q;

  logic [35:0] sr_d [SqN];
  logic [31:0] rt_d [SqN];
  logic [63:0] sn_d [SqN];
  logic [35:0] sr_q [SqN];
  logic [31:0] rt_q [SqN];
  logic [63:0] sn_q [SqN];

  logic [61:0] nn_d [3];
  logic [31:0] sdl_q;
  logic [31:0] sdr_q [3];
  logic [31:0] sdn_q [3];

  logic [31:0] dr_d [DvN][3];
  logic [31:0] dn_d [DvN][3];
  logic [31:0] dq_d [DvN][3];
  logic [31:0] dr_q [DvN][3];
  logic [31:0] dn_q [DvN][3];
  logic [31:0] dq_q [DvN][3];
  logic [31:0] dl_q [DvN];

  word_t o_d [3];
  word_t o_q [3];

  // abs and max
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vec_i[i][63];
      mag_d[i] = neg_d[i] ? 63'(-vec_i[i]) : vec_i[i][62:0];
    end
    zero_d = (vec_i[0] == '0) && (vec_i[1] == '0) && (vec_i[2] == '0);
    mx_d = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
    if (mag_d[2] > mx_d) begin
      mx_d = mag_d[2];
    end
  end

  // leading one: byte group, then bit
  always_comb begin
    mx64   = {1'b0, mx_q};
    grp_d  = '0;
    for (int g = 0; g < 8; g++) begin
      if (mx64[8*g +: 8] != '0) begin
        grp_d = 3'(g);
      end
    end
    byte_d = mx64[grp_d*8 +: 8];
  end

  always_comb begin
    pos_d = {grp_q, 3'd0};
    for (int b = 0; b < 8; b++) begin
      if (byte_q[b]) begin
        pos_d = {grp_q, 3'(b)};
      end
    end
  end

  // scale so the largest lies in [2^30, 2^31)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_q > 6'd30) begin
        m_d[i] = 31'(mag_q[2][i] >> (pos_q - 6'd30));
      end else begin
        m_d[i] = 31'(mag_q[2][i] << (6'd30 - pos_q));
      end
    end
  end

  // integer square root, two result bits per stage
  always_comb begin
    logic [35:0] r;
    logic [31:0] t;
    logic [63:0] n;
    for (int k = 0; k < SqN; k++) begin
      if (k == 0) begin
        r = '0;
        t = '0;
        n = sum_q;
      end else begin
        r = sr_q[k-1];
        t = rt_q[k-1];
        n = sn_q[k-1];
      end
      for (int s = 0; s < Steps; s++) begin
        r = {r[33:0], n[63:62]};
        n = {n[61:0], 2'b00};
        if (r >= {2'b00, t, 2'b01}) begin
          r = r - {2'b00, t, 2'b01};
          t = {t[30:0], 1'b1};
        end else begin
          t = {t[30:0], 1'b0};
        end
      end
      sr_d[k] = r;
      rt_d[k] = t;
      sn_d[k] = n;
    end
  end

  // rounded dividend
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nn_d[i] = {m_q[SdIdx-1][i], 31'd0} >> 1;
      nn_d[i] = nn_d[i] + 62'(rt_q[SqN-1] >> 1);
    end
  end

  // restoring division, two quotient bits per stage
  always_comb begin
    logic [32:0] r;
    logic [31:0] n;
    logic [31:0] q;
    logic [31:0] l;
    for (int k = 0; k < DvN; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          r = {1'b0, sdr_q[i]};
          n = sdn_q[i];
          q = '0;
          l = sdl_q;
        end else begin
          r = {1'b0, dr_q[k-1][i]};
          n = dn_q[k-1][i];
          q = dq_q[k-1][i];
          l = dl_q[k-1];
        end
        for (int s = 0; s < Steps; s++) begin
          r = {r[31:0], n[31]};
          n = {n[30:0], 1'b0};
          if (r >= {1'b0, l}) begin
            r = r - {1'b0, l};
            q = {q[30:0], 1'b1};
          end else begin
            q = {q[30:0], 1'b0};
          end
        end
        dr_d[k][i] = r[31:0];
        dn_d[k][i] = n;
        dq_d[k][i] = q;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zero_q[OutIdx-1]) begin
        o_d[i] = '0;
      end else if (neg_q[OutIdx-1][i]) begin
        o_d[i] = word_t'(-dq_q[DvN-1][i]);
      end else begin
        o_d[i] = word_t'(dq_q[DvN-1][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSt-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= neg_d;
      zero_q[0] <= zero_d;
      side_q[0] <= side_i;
      for (int k = 1; k < NSt; k++) begin
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
        side_q[k] <= side_q[k-1];
      end
      mag_q[0] <= mag_d;
      mag_q[1] <= mag_q[0];
      mag_q[2] <= mag_q[1];
      mx_q     <= mx_d;
      grp_q    <= grp_d;
      byte_q   <= byte_d;
      pos_q    <= pos_d;
      m_q[3]   <= m_d;
      for (int k = 4; k < SdIdx; k++) begin
        m_q[k] <= m_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        sq_q[i]  <= m_q[3][i] * m_q[3][i];
        sdr_q[i] <= {2'b00, nn_d[i][61:32]};
        sdn_q[i] <= nn_d[i][31:0];
      end
      sum_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
      sr_q  <= sr_d;
      rt_q  <= rt_d;
      sn_q  <= sn_d;
      sdl_q <= rt_q[SqN-1];
      dr_q  <= dr_d;
      dn_q  <= dn_d;
      dq_q  <= dq_d;
      dl_q[0] <= sdl_q;
      for (int k = 1; k < DvN; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
      o_q <= o_d;
    end
  end

  assign valid_o = vld_q[OutIdx];
  assign side_o  = side_q[OutIdx];
  assign vec_o   = o_q;

endmodule

/* sv/look_at_view_matrix.sv */
// Look-at view matrix, fully pipelined: one word accepted per cycle while not
// stalled. From input accept to output valid: three 40-stage
// normalizers (16-stage square root, 16-stage divider each), two cross stages
// each, dot stages, and a 2-word output buffer. A stall freezes the pipeline.
// Reset clears the valid bits and empties the output buffer; no other state.
`timescale 1ns / 1ps

module look_at_view_matrix import lkat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lkat_chan_if.sink   in_i,
  lkat_chan_if.source out_o
);

  logic  en;
  logic  v0_q;
  word_t eye0_q [3];
  word_t up0_q  [3];
  wide_t diff0_q [3];

  logic          bk_v;
  word_t         bk [3];
  logic [191:0]  bk_side;
  word_t         s1_up [3];

  logic          x1v_q, x2v_q;
  wide_t         x1p_q [6];
  wide_t         x2c_q [3];
  logic [95:0]   x1e_q, x2e_q;
  word_t         x1b_q [3];
  word_t         x2b_q [3];

  logic          rt_v;
  word_t         rt [3];
  logic [191:0]  rt_side;
  word_t         s2_bk [3];

  logic          y1v_q, y2v_q;
  wide_t         y1p_q [6];
  wide_t         y2c_q [3];
  logic [287:0]  y1s_q, y2s_q;

  logic          tu_v;
  word_t         tu [3];
  logic [287:0]  tu_side;
  word_t         ax [9];
  word_t         s3_eye [3];

  logic          d1v_q, d2v_q;
  wide_t         d1p_q [9];
  word_t         d1ax_q [9];
  word_t         d2ax_q [9];
  logic signed [65:0] d2t_q [3];

  logic signed [65:0] rnd [3];
  logic signed [35:0] sh36 [3];
  word_t              trans [3];
  out_t               res;

  out_t        fifo_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign en         = (cnt_q != 2'd2) || out_o.ready;
  assign in_i.ready = en;
  assign push       = en && d2v_q;
  assign pop        = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      x1v_q <= 1'b0;
      x2v_q <= 1'b0;
      y1v_q <= 1'b0;
      y2v_q <= 1'b0;
      d1v_q <= 1'b0;
      d2v_q <= 1'b0;
    end else if (en) begin
      v0_q  <= in_i.valid;
      x1v_q <= bk_v;
      x2v_q <= x1v_q;
      y1v_q <= rt_v;
      y2v_q <= y1v_q;
      d1v_q <= tu_v;
      d2v_q <= d1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye0_q[0]  <= in_i.data.eye_x;
      eye0_q[1]  <= in_i.data.eye_y;
      eye0_q[2]  <= in_i.data.eye_z;
      up0_q[0]   <= in_i.data.up_x;
      up0_q[1]   <= in_i.data.up_y;
      up0_q[2]   <= in_i.data.up_z;
      diff0_q[0] <= wide_t'(in_i.data.eye_x) - wide_t'(in_i.data.target_x);
      diff0_q[1] <= wide_t'(in_i.data.eye_y) - wide_t'(in_i.data.target_y);
      diff0_q[2] <= wide_t'(in_i.data.eye_z) - wide_t'(in_i.data.target_z);
    end
  end

  lkat_norm #(.SIDE_W(192)) u_norm_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .vec_i   (diff0_q),
    .side_i  ({eye0_q[0], eye0_q[1], eye0_q[2], up0_q[0], up0_q[1], up0_q[2]}),
    .valid_o (bk_v),
    .vec_o   (bk),
    .side_o  (bk_side)
  );

  assign s1_up[0] = word_t'(bk_side[95:64]);
  assign s1_up[1] = word_t'(bk_side[63:32]);
  assign s1_up[2] = word_t'(bk_side[31:0]);

  // right = up x back
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1p_q[0] <= s1_up[1] * bk[2];
      x1p_q[1] <= s1_up[2] * bk[1];
      x1p_q[2] <= s1_up[2] * bk[0];
      x1p_q[3] <= s1_up[0] * bk[2];
      x1p_q[4] <= s1_up[0] * bk[1];
      x1p_q[5] <= s1_up[1] * bk[0];
      x1e_q    <= bk_side[191:96];
      x1b_q    <= bk;
      for (int i = 0; i < 3; i++) begin
        x2c_q[i] <= x1p_q[2*i] - x1p_q[2*i+1];
      end
      x2e_q <= x1e_q;
      x2b_q <= x1b_q;
    end
  end

  lkat_norm #(.SIDE_W(192)) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (x2v_q),
    .vec_i   (x2c_q),
    .side_i  ({x2e_q, x2b_q[0], x2b_q[1], x2b_q[2]}),
    .valid_o (rt_v),
    .vec_o   (rt),
    .side_o  (rt_side)
  );

  assign s2_bk[0] = word_t'(rt_side[95:64]);
  assign s2_bk[1] = word_t'(rt_side[63:32]);
  assign s2_bk[2] = word_t'(rt_side[31:0]);

  // true up = back x right
  always_ff @(posedge clk_i) begin
    if (en) begin
      y1p_q[0] <= s2_bk[1] * rt[2];
      y1p_q[1] <= s2_bk[2] * rt[1];
      y1p_q[2] <= s2_bk[2] * rt[0];
      y1p_q[3] <= s2_bk[0] * rt[2];
      y1p_q[4] <= s2_bk[0] * rt[1];
      y1p_q[5] <= s2_bk[1] * rt[0];
      y1s_q    <= {rt_side, rt[0], rt[1], rt[2]};
      for (int i = 0; i < 3; i++) begin
        y2c_q[i] <= y1p_q[2*i] - y1p_q[2*i+1];
      end
      y2s_q <= y1s_q;
    end
  end

  lkat_norm #(.SIDE_W(288)) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (y2v_q),
    .vec_i   (y2c_q),
    .side_i  (y2s_q),
    .valid_o (tu_v),
    .vec_o   (tu),
    .side_o  (tu_side)
  );

  // axes in output order: right, true up, back
  assign ax[0] = word_t'(tu_side[95:64]);
  assign ax[1] = word_t'(tu_side[63:32]);
  assign ax[2] = word_t'(tu_side[31:0]);
  assign ax[3] = tu[0];
  assign ax[4] = tu[1];
  assign ax[5] = tu[2];
  assign ax[6] = word_t'(tu_side[191:160]);
  assign ax[7] = word_t'(tu_side[159:128]);
  assign ax[8] = word_t'(tu_side[127:96]);
  assign s3_eye[0] = word_t'(tu_side[287:256]);
  assign s3_eye[1] = word_t'(tu_side[255:224]);
  assign s3_eye[2] = word_t'(tu_side[223:192]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          d1p_q[3*a+i] <= ax[3*a+i] * s3_eye[i];
        end
        d2t_q[a] <= -(66'(d1p_q[3*a]) + 66'(d1p_q[3*a+1]) + 66'(d1p_q[3*a+2]));
      end
      d1ax_q <= ax;
      d2ax_q <= d1ax_q;
    end
  end

  // round half up, drop axis fraction, saturate
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rnd[a]  = d2t_q[a] + (66'sd1 <<< (AxisFrac - 1));
      sh36[a] = 36'(rnd[a] >>> AxisFrac);
      if (sh36[a] > 36'sh07fffffff) begin
        trans[a] = word_t'(32'h7fffffff);
      end else if (sh36[a] < -36'sh080000000) begin
        trans[a] = word_t'(32'h80000000);
      end else begin
        trans[a] = word_t'(sh36[a][31:0]);
      end
    end
    res.right_x   = d2ax_q[0];
    res.right_y   = d2ax_q[1];
    res.right_z   = d2ax_q[2];
    res.true_up_x = d2ax_q[3];
    res.true_up_y = d2ax_q[4];
    res.true_up_z = d2ax_q[5];
    res.back_x    = d2ax_q[6];
    res.back_y    = d2ax_q[7];
    res.back_z    = d2ax_q[8];
    res.trans_x   = trans[0];
    res.trans_y   = trans[1];
    res.trans_z   = trans[2];
  end

  // output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= res;
    end
  end

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = fifo_q[rp_q];

endmodule
